// ===== rtl/eg_pkg.sv =====
// Package for the nibble ElGamal decryptor: widths, reset values, lane FSM states.
// No dependencies.
package eg_pkg;
  localparam int unsigned MOD_W_DEFAULT = 32;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET = 1'b1;
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd65537;
  localparam logic [FIELD_W-1:0] SECRET_RESET = 32'd12345;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [2:0] {
    L_IDLE, L_RED, L_EXP1, L_EXP2, L_FINAL, L_DONE
  } lane_state_t;

  // Operation codes for the modular multiplier.
  typedef enum logic [1:0] {
    MM_RED, MM_MUL
  } mm_op_t;
endpackage

// ===== rtl/eg_mulmod.sv =====
// Bit-serial modular multiplier: r = a*b mod p, one bit of b per cycle.
// Depends on eg_pkg.
module eg_mulmod #(
  parameter int unsigned MOD_W = eg_pkg::MOD_W_DEFAULT,
  parameter int unsigned OPB_W = MOD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MOD_W-1:0] a,
  input  logic [OPB_W-1:0] b,
  input  logic [MOD_W-1:0] p,
  output logic             busy,
  output logic             done,
  output logic [MOD_W-1:0] r
);
  import eg_pkg::*;
  localparam int unsigned CNT_W = $clog2(OPB_W + 1);

  logic [MOD_W-1:0] opa, modp, acc;
  logic [OPB_W-1:0] opb;
  logic [CNT_W-1:0] cnt;
  logic [MOD_W:0] dbl, dbl_r, add, add_r;
  logic [MOD_W-1:0] acc_next;

  // Double, reduce, conditionally add, reduce.
  always_comb begin
    dbl = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, modp}) ? dbl - {1'b0, modp} : dbl;
    add = dbl_r + {1'b0, opa};
    add_r = (add >= {1'b0, modp}) ? add - {1'b0, modp} : add;
    acc_next = opb[OPB_W-1] ? add_r[MOD_W-1:0] : dbl_r[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start && !busy) begin
        busy <= 1'b1;
        opa <= a;
        opb <= b;
        modp <= p;
        acc <= '0;
        cnt <= CNT_W'(OPB_W);
      end else if (busy) begin
        acc <= acc_next;
        opb <= {opb[OPB_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  assign r = acc;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("mulmod done while busy");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("mulmod did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> r < modp)
    else $error("mulmod result not reduced");
endmodule

// ===== rtl/eg_lane.sv =====
// One decryption lane: m = b * (a^x)^(p-2) mod p, low nibble kept.
// Depends on eg_pkg and eg_mulmod.
module eg_lane #(
  parameter int unsigned MOD_W = eg_pkg::MOD_W_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eg_pkg::FIELD_W-1:0]  ephemeral,
  input  logic [eg_pkg::FIELD_W-1:0]  masked,
  input  logic [MOD_W-1:0]            p,
  input  logic [eg_pkg::FIELD_W-1:0]  x,
  output logic                        done,
  output logic [3:0]                  nibble
);
  import eg_pkg::*;
  localparam int unsigned EXP_W = (MOD_W > FIELD_W) ? MOD_W : FIELD_W;
  localparam int unsigned ECNT_W = $clog2(EXP_W + 1);

  lane_state_t state, state_next;
  logic [MOD_W-1:0] res, base, bred, m_a, m_r;
  logic [EXP_W-1:0] m_b;
  logic [EXP_W-1:0] ex;
  logic [ECNT_W-1:0] ecnt;
  logic phase;        // 0: multiply res by base, 1: square base
  logic red_step;     // 0: reduce a, 1: reduce b
  logic mm_start, mm_busy, mm_done;
  logic [EXP_W-1:0] in_a, in_b;
  logic [MOD_W:0] pm2;

  // Zero-extend the fields; the multiplier walks all their bits to reduce them.
  always_comb begin
    in_a = EXP_W'(ephemeral);
    in_b = EXP_W'(masked);
  end
  assign pm2 = {1'b0, p} - (MOD_W+1)'(2);

  eg_mulmod #(.MOD_W(MOD_W), .OPB_W(EXP_W)) u_mm (
    .clk(clk), .rst(rst), .start(mm_start), .a(m_a), .b(m_b), .p(p),
    .busy(mm_busy), .done(mm_done), .r(m_r)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE:  if (start) state_next = L_RED;
      L_RED:   if (mm_done && red_step) state_next = L_EXP1;
      L_EXP1:  if (ecnt == '0 && !mm_busy && !mm_done) state_next = L_EXP2;
      L_EXP2:  if (ecnt == '0 && !mm_busy && !mm_done) state_next = L_FINAL;
      L_FINAL: if (mm_done) state_next = L_DONE;
      L_DONE:  state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  // Multiplier operand selection; 1*a mod p, a Horner pass over a, reduces a.
  always_comb begin
    m_a = '0;
    m_b = '0;
    mm_start = 1'b0;
    unique case (state)
      L_RED: begin
        m_a = MOD_W'(1);
        m_b = red_step ? in_b : in_a;
        mm_start = !mm_busy && !mm_done;
      end
      L_EXP1, L_EXP2: begin
        m_a = phase ? base : res;
        m_b = EXP_W'(base);
        mm_start = (ecnt != '0) && !mm_busy && !mm_done && (phase || ex[0]);
      end
      L_FINAL: begin
        m_a = bred;
        m_b = EXP_W'(res);
        mm_start = !mm_busy && !mm_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      L_IDLE: begin
        red_step <= 1'b0;
      end
      L_RED: if (mm_done) begin
        if (!red_step) begin
          base <= m_r;
          red_step <= 1'b1;
        end else begin
          bred <= m_r;
          res <= MOD_W'(1);
          ex <= EXP_W'(x);
          ecnt <= ECNT_W'(FIELD_W);
          phase <= 1'b0;
        end
      end
      L_EXP1, L_EXP2: begin
        if (ecnt == '0 && !mm_busy && !mm_done) begin
          if (state == L_EXP1) begin
            // Start second exponentiation from s = res.
            base <= res;
            res <= MOD_W'(1);
            ex <= EXP_W'(pm2[MOD_W-1:0]);
            ecnt <= ECNT_W'(MOD_W);
            phase <= 1'b0;
          end
        end else if ((ecnt != '0) && !mm_busy && !mm_done && !phase && !ex[0]) begin
          // Skip the multiply for a zero bit.
          phase <= 1'b1;
        end else if (mm_done) begin
          if (!phase) begin
            res <= m_r;
            phase <= 1'b1;
          end else begin
            base <= m_r;
            phase <= 1'b0;
            ex <= ex >> 1;
            ecnt <= ecnt - 1'b1;
          end
        end
      end
      L_FINAL: if (mm_done) nibble <= m_r[3:0] & NIBBLE_MASK;
      default: ;
    endcase
  end

  assign done = (state == L_DONE);

  assert property (@(posedge clk) disable iff (rst) done |=> state == L_IDLE)
    else $error("lane did not return to idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == L_IDLE && !start) |=> state == L_IDLE)
    else $error("lane left idle without start");
endmodule

// ===== rtl/elgamal_nibble_decrypt_top.sv =====
// Channel    | Signals                                   | Dir
// request    | in_valid/in_ready, high_*/low_* fields     | in
// result     | out_valid/out_ready, plain_byte            | out
// config     | cfg_we, cfg_index, cfg_data                | in
// Two lanes run the high and low nibble side by side, each on its own
// bit-serial multiplier. A request runs two exponentiations, of 32 and MOD_W
// bits, at worst each bit a multiply and a square. The result waits in an
// output register; the next request is taken once the result has been
// accepted. Reset (rst, synchronous) loads the register defaults and empties
// the block.
module elgamal_nibble_decrypt_top #(
  parameter int unsigned MOD_W = eg_pkg::MOD_W_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [eg_pkg::FIELD_W-1:0]    high_ephemeral,
  input  logic [eg_pkg::FIELD_W-1:0]    high_masked,
  input  logic [eg_pkg::FIELD_W-1:0]    low_ephemeral,
  input  logic [eg_pkg::FIELD_W-1:0]    low_masked,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    plain_byte,
  input  logic                          cfg_we,
  input  logic [eg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eg_pkg::FIELD_W-1:0]    cfg_data
);
  import eg_pkg::*;

  logic [MOD_W-1:0] modulus;
  logic [FIELD_W-1:0] secret_exponent;
  logic busy, small_p, start;
  logic hi_done, lo_done, hi_seen, lo_seen;
  logic [3:0] hi_nib, lo_nib;
  logic [FIELD_W-1:0] ha, hb, la, lb;

  assign small_p = (modulus < MOD_W'(2));
  assign in_ready = !busy && !out_valid;
  assign start = in_valid && in_ready && !small_p;

  // Config writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_W'(MODULUS_RESET);
      secret_exponent <= SECRET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: modulus <= MOD_W'(cfg_data);
        REG_SECRET:  secret_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture request fields for the lanes.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ha <= high_ephemeral;
      hb <= high_masked;
      la <= low_ephemeral;
      lb <= low_masked;
    end
  end

  logic go;
  always_ff @(posedge clk) begin
    if (rst) go <= 1'b0;
    else go <= start;
  end

  eg_lane #(.MOD_W(MOD_W)) u_hi (
    .clk(clk), .rst(rst), .start(go), .ephemeral(ha), .masked(hb),
    .p(modulus), .x(secret_exponent), .done(hi_done), .nibble(hi_nib)
  );
  eg_lane #(.MOD_W(MOD_W)) u_lo (
    .clk(clk), .rst(rst), .start(go), .ephemeral(la), .masked(lb),
    .p(modulus), .x(secret_exponent), .done(lo_done), .nibble(lo_nib)
  );

  // Merge lane results into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      hi_seen <= 1'b0;
      lo_seen <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        if (small_p) begin
          plain_byte <= '0;
          out_valid <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end
      if (busy && (hi_seen || hi_done) && (lo_seen || lo_done)) begin
        plain_byte <= {hi_nib, lo_nib};
        out_valid <= 1'b1;
        busy <= 1'b0;
        hi_seen <= 1'b0;
        lo_seen <= 1'b0;
      end else begin
        if (hi_done) hi_seen <= 1'b1;
        if (lo_done) lo_seen <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("accepted two requests back to back");
  assert property (@(posedge clk) disable iff (rst) !(busy && out_valid))
    else $error("busy with result pending");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for elgamal_nibble_decrypt_top: random and directed
// ciphertext requests with an in-bench ElGamal predictor and a byte scoreboard.
// Depends on rtl/eg_pkg.sv and rtl/elgamal_nibble_decrypt_top.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eg_pkg::*;

  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 50;

  // Idle profiles of the two channels
  typedef enum int {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_t;

  // Expected plaintext bytes plus the key material they are computed under
  class byte_scoreboard;
    logic [7:0] expected_bytes[$];
    longint unsigned modulus_p;
    longint unsigned secret_x;
    int errors;

    function new();
      modulus_p = MODULUS_RESET;
      secret_x = SECRET_RESET;
      errors = 0;
    endfunction

    function longint unsigned mul_mod(longint unsigned a, longint unsigned b);
      return (a * b) % modulus_p;
    endfunction

    function longint unsigned pow_mod(longint unsigned base, longint unsigned e);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % modulus_p;
      sq = base % modulus_p;
      while (e != 0) begin
        if (e[0]) acc = mul_mod(acc, sq);
        sq = mul_mod(sq, sq);
        e = e >> 1;
      end
      return acc;
    endfunction

    // m = b * (a^x)^(p-2) mod p
    function logic [3:0] plain_nibble(logic [31:0] eph, logic [31:0] masked);
      longint unsigned shared_s;
      longint unsigned inv_t;
      longint unsigned m;
      shared_s = pow_mod(eph, secret_x);
      inv_t = pow_mod(shared_s, modulus_p - 2);
      m = mul_mod(masked % modulus_p, inv_t);
      return m[3:0] & NIBBLE_MASK;
    endfunction

    function void note_request(logic [31:0] he, logic [31:0] hm,
                               logic [31:0] le, logic [31:0] lm);
      if (modulus_p < 2) expected_bytes.push_back(8'h00);
      else expected_bytes.push_back({plain_nibble(he, hm), plain_nibble(le, lm)});
    endfunction

    function void check_byte(logic [7:0] actual);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        $error("plain_byte: unexpected result 0x%02h", actual);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (actual !== want) begin
        $error("plain_byte: expected 0x%02h, actual 0x%02h", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FIELD_W-1:0] high_ephemeral = '0;
  logic [FIELD_W-1:0] high_masked = '0;
  logic [FIELD_W-1:0] low_ephemeral = '0;
  logic [FIELD_W-1:0] low_masked = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] plain_byte;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
  logic [FIELD_W-1:0] cfg_data = '0;

  byte_scoreboard decrypt_sb = new();
  idle_mode_t idle_mode = IDLE_NONE;
  int unsigned quiet_cycles = 0;

  elgamal_nibble_decrypt_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .high_ephemeral(high_ephemeral), .high_masked(high_masked),
    .low_ephemeral(low_ephemeral), .low_masked(low_masked),
    .out_valid(out_valid), .out_ready(out_ready), .plain_byte(plain_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check results, stall the receiver, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) decrypt_sb.check_byte(plain_byte);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
    if (idle_mode == IDLE_RECEIVER) out_ready <= ($urandom_range(99) >= 88);
    else if (idle_mode == IDLE_BOTH) out_ready <= ($urandom_range(99) >= 23);
    else out_ready <= 1'b1;
  end

  // Hold one request until accepted, after an optional sender gap
  task automatic send_request(logic [31:0] he, logic [31:0] hm,
                              logic [31:0] le, logic [31:0] lm);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 23 : 0;
    while ($urandom_range(99) < pct && gap < 200) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    high_ephemeral <= he;
    high_masked <= hm;
    low_ephemeral <= le;
    low_masked <= lm;
    do @(posedge clk); while (!in_ready);
    decrypt_sb.note_request(he, hm, le, lm);
  endtask

  // Drain, then write one register while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    in_valid <= 1'b0;
    while (decrypt_sb.expected_bytes.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) decrypt_sb.modulus_p = value;
    else decrypt_sb.secret_x = value;
  endtask

  // Ciphertext word: full range, small, multiples of p, near p or near 2^32
  function automatic logic [31:0] pick_word();
    longint unsigned p;
    longint unsigned k;
    p = decrypt_sb.modulus_p;
    case ($urandom_range(5))
      0: return $urandom_range(15);
      1: begin
        k = $urandom_range(7);
        return 32'(p * k);
      end
      2: return 32'(p + $urandom_range(3) - 1);
      3: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count, idle_mode_t mode);
    idle_mode = mode;
    repeat (count) send_request(pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key: zero, p and its multiples, all-ones words, plain values
    idle_mode = IDLE_NONE;
    send_request(32'd0, 32'd0, 32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd65537, 32'd5, 32'd131074, 32'd9);
    send_request(32'd1, 32'd7, 32'd1, 32'd65536);
    send_request(32'd3, 32'd65538, 32'd65536, 32'hFFFF_FFFF);
    send_request(32'd0, 32'd12, 32'd65537, 32'd3);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    run_random(90, IDLE_NONE);

    // Modulus two: inverse exponent zero, m = b mod 2
    write_reg(REG_MODULUS, 32'd2);
    write_reg(REG_SECRET, 32'hFFFF_FFFF);
    send_request(32'd0, 32'd1, 32'd2, 32'd3);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    run_random(80, IDLE_SENDER);

    // Small prime, key one
    write_reg(REG_MODULUS, 32'd251);
    write_reg(REG_SECRET, 32'd1);
    send_request(32'd251, 32'd250, 32'd502, 32'd1);
    run_random(150, IDLE_RECEIVER);

    // Largest 32-bit prime, all-ones key
    write_reg(REG_MODULUS, 32'd4294967291);
    write_reg(REG_SECRET, 32'hFFFF_FFFF);
    send_request(32'd4294967291, 32'hFFFF_FFFF, 32'hFFFF_FFFA, 32'hFFFF_FFFC);
    run_random(40, IDLE_BOTH);

    // Composite modulus: garbage but still deterministic
    write_reg(REG_MODULUS, 32'd1000);
    write_reg(REG_SECRET, 32'd77);
    run_random(140, IDLE_SENDER);

    write_reg(REG_MODULUS, 32'd13);
    write_reg(REG_SECRET, 32'h8000_0001);
    run_random(140, IDLE_BOTH);

    // Drain and let the block settle
    in_valid <= 1'b0;
    while (decrypt_sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decrypt_sb.errors == 0 && decrypt_sb.expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== elgamal_nibble_decrypt_top.f =====
rtl/eg_pkg.sv
rtl/eg_mulmod.sv
rtl/eg_lane.sv
rtl/elgamal_nibble_decrypt_top.sv
verif/tb.sv
